[rtl/jiftq_pkg.sv]
// ----------------------------------------------------------------------------
// Joint impedance filtered torque: shared package
// Command codes, register indexes, register reset values and the
// configuration bundle handed from the register file to the datapath.
// ----------------------------------------------------------------------------
package jiftq_pkg;

  // Number of joints held in the state memories.
  localparam int unsigned JOINT_COUNT = 7;
  // Width of the joint index field.
  localparam int unsigned JOINT_W = 3;
  // Width of a configuration register index.
  localparam int unsigned CFG_IDX_W = 4;
  // Width of configuration write data.
  localparam int unsigned CFG_DATA_W = 32;

  // Item command codes.
  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_TARGET = 2'd1,
    CMD_SYNC   = 2'd2
  } cmd_e_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS   = 4'd0,
    REG_DAMPING     = 4'd1,
    REG_FILT_STIFF  = 4'd2,
    REG_FILT_DAMP   = 4'd3,
    REG_VEL_LIMIT   = 4'd4,
    REG_ACCEL_LIMIT = 4'd5,
    REG_STEP_LIMIT  = 4'd6,
    REG_TIME_STEP   = 4'd7
  } cfg_reg_e_t;

  // Reset values of the configuration registers.
  localparam logic [30:0] RST_STIFFNESS   = 31'd0;
  localparam logic [30:0] RST_DAMPING     = 31'd0;
  localparam logic [30:0] RST_FILT_STIFF  = 31'd26214400;
  localparam logic [30:0] RST_FILT_DAMP   = 31'd2621440;
  localparam logic [30:0] RST_VEL_LIMIT   = 31'd32768;
  localparam logic [30:0] RST_ACCEL_LIMIT = 31'd327680;
  localparam logic [30:0] RST_STEP_LIMIT  = 31'd65536;
  localparam logic [31:0] RST_TIME_STEP   = 32'd4294967;

  // Current configuration, as seen by the datapath.
  typedef struct packed {
    logic [30:0] stiffness;
    logic [30:0] damping;
    logic [30:0] filt_stiff;
    logic [30:0] filt_damp;
    logic [30:0] vel_limit;
    logic [30:0] accel_limit;
    logic [30:0] step_limit;
    logic [31:0] time_step;
  } cfg_t;

endpackage

[rtl/jiftq_if.sv]
// ----------------------------------------------------------------------------
// Joint impedance filtered torque: channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface jiftq_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [jiftq_pkg::JOINT_W-1:0]  joint;
  logic signed [VALUE_WIDTH-1:0]  measured_position;
  logic signed [VALUE_WIDTH-1:0]  measured_velocity;
  logic signed [VALUE_WIDTH-1:0]  coriolis_torque;
  logic signed [VALUE_WIDTH-1:0]  prior_torque;
  logic signed [VALUE_WIDTH-1:0]  target_position;
  logic signed [VALUE_WIDTH-1:0]  target_velocity;

  modport source (
    output valid, cmd, joint, measured_position, measured_velocity,
           coriolis_torque, prior_torque, target_position, target_velocity,
    input  ready
  );
  modport sink (
    input  valid, cmd, joint, measured_position, measured_velocity,
           coriolis_torque, prior_torque, target_position, target_velocity,
    output ready
  );
endinterface

interface jiftq_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [jiftq_pkg::JOINT_W-1:0]  out_joint;
  logic signed [VALUE_WIDTH-1:0]  torque_command;
  logic signed [VALUE_WIDTH-1:0]  filtered_position;
  logic signed [VALUE_WIDTH-1:0]  filtered_velocity;
  logic signed [VALUE_WIDTH-1:0]  filtered_accel;

  modport source (
    output valid, out_joint, torque_command, filtered_position,
           filtered_velocity, filtered_accel,
    input  ready
  );
  modport sink (
    input  valid, out_joint, torque_command, filtered_position,
           filtered_velocity, filtered_accel,
    output ready
  );
endinterface

interface jiftq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [jiftq_pkg::CFG_IDX_W-1:0]   index;
  logic [jiftq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/jiftq_ram.sv]
// ----------------------------------------------------------------------------
// Joint impedance filtered torque: generic RAM
// One write port and one read port with registered read data (read-old).
// ----------------------------------------------------------------------------
module jiftq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 7
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/jiftq_cfg.sv]
// ----------------------------------------------------------------------------
// Joint impedance filtered torque: configuration registers
// Holds the gains, limits and control period written over the register port.
// ----------------------------------------------------------------------------
module jiftq_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  jiftq_cfg_if.sink            cfg_ch,
  output jiftq_pkg::cfg_t      cfg
);

  jiftq_pkg::cfg_t cfg_r;
  jiftq_pkg::cfg_t cfg_nxt;

  // The port never stalls.
  assign cfg_ch.ready = 1'b1;

  // Decode a write transaction; unknown indexes leave the registers alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        jiftq_pkg::REG_STIFFNESS:   cfg_nxt.stiffness   = cfg_ch.data[30:0];
        jiftq_pkg::REG_DAMPING:     cfg_nxt.damping     = cfg_ch.data[30:0];
        jiftq_pkg::REG_FILT_STIFF:  cfg_nxt.filt_stiff  = cfg_ch.data[30:0];
        jiftq_pkg::REG_FILT_DAMP:   cfg_nxt.filt_damp   = cfg_ch.data[30:0];
        jiftq_pkg::REG_VEL_LIMIT:   cfg_nxt.vel_limit   = cfg_ch.data[30:0];
        jiftq_pkg::REG_ACCEL_LIMIT: cfg_nxt.accel_limit = cfg_ch.data[30:0];
        jiftq_pkg::REG_STEP_LIMIT:  cfg_nxt.step_limit  = cfg_ch.data[30:0];
        jiftq_pkg::REG_TIME_STEP:   cfg_nxt.time_step   = cfg_ch.data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness   <= jiftq_pkg::RST_STIFFNESS;
      cfg_r.damping     <= jiftq_pkg::RST_DAMPING;
      cfg_r.filt_stiff  <= jiftq_pkg::RST_FILT_STIFF;
      cfg_r.filt_damp   <= jiftq_pkg::RST_FILT_DAMP;
      cfg_r.vel_limit   <= jiftq_pkg::RST_VEL_LIMIT;
      cfg_r.accel_limit <= jiftq_pkg::RST_ACCEL_LIMIT;
      cfg_r.step_limit  <= jiftq_pkg::RST_STEP_LIMIT;
      cfg_r.time_step   <= jiftq_pkg::RST_TIME_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/jiftq_core.sv]
// ----------------------------------------------------------------------------
// Joint impedance filtered torque: datapath
// Reads the joint state from the reference and goal RAMs, runs the filter and
// the torque law through a pipeline and writes the state back.
// ----------------------------------------------------------------------------
module jiftq_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jiftq_pkg::cfg_t   cfg,
  jiftq_in_if.sink          in_ch,
  jiftq_out_if.source       out_ch
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned AW = (jiftq_pkg::JOINT_COUNT > 1) ?
                               $clog2(jiftq_pkg::JOINT_COUNT) : 1;
  localparam int unsigned PW = VW + 33;
  localparam int unsigned RW = 2 * VW;
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                    cmd;
    logic [jiftq_pkg::JOINT_W-1:0] joint;
    logic [VW-1:0]                 q;
    logic [VW-1:0]                 dq;
    logic [VW-1:0]                 cor;
    logic [VW-1:0]                 prior;
    logic [VW-1:0]                 tp;
    logic [VW-1:0]                 tv;
  } item_t;

  // --------------------------------------------------------------------------
  // Saturating arithmetic helpers.
  // --------------------------------------------------------------------------
  function automatic logic [VW-1:0] sat_w(input logic [VW:0] x);
    logic [VW-1:0] r;
    if (x[VW] != x[VW-1]) begin
      r = x[VW] ? VMIN : VMAX;
    end else begin
      r = x[VW-1:0];
    end
    return r;
  endfunction

  function automatic logic [VW-1:0] add_s(input logic [VW-1:0] a,
                                          input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    return sat_w(s);
  endfunction

  function automatic logic [VW-1:0] sub_s(input logic [VW-1:0] a,
                                          input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    return sat_w(s);
  endfunction

  // floor(a * g / 2^16) or floor(a * g / 2^32), saturated.
  function automatic logic [VW-1:0] mulq(input logic [VW-1:0] a,
                                         input logic [31:0]   g,
                                         input logic          by32);
    logic signed [VW-1:0] as;
    logic signed [32:0]   gs;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] sh;
    logic [VW-1:0]        r;
    as = a;
    gs = {1'b0, g};
    p  = as * gs;
    sh = by32 ? (p >>> 32) : (p >>> 16);
    if ((&sh[PW-1:VW-1]) || !(|sh[PW-1:VW-1])) begin
      r = sh[VW-1:0];
    end else begin
      r = sh[PW-1] ? VMIN : VMAX;
    end
    return r;
  endfunction

  // Symmetric clamp against an unsigned 31-bit limit.
  function automatic logic [VW-1:0] clamp_s(input logic [VW-1:0] x,
                                            input logic [30:0]   lim);
    logic [VW+31:0] le;
    logic [VW+31:0] vm;
    logic [VW+31:0] lc;
    logic [VW-1:0]  l;
    logic [VW-1:0]  nl;
    logic [VW-1:0]  r;
    le = (VW+32)'(lim);
    vm = (VW+32)'(VMAX);
    lc = (le > vm) ? vm : le;
    l  = lc[VW-1:0];
    nl = ~l + 1'b1;
    if ($signed(x) > $signed(l)) begin
      r = l;
    end else if ($signed(x) < $signed(nl)) begin
      r = nl;
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic logic is_step(input logic [1:0] c);
    return c == jiftq_pkg::CMD_STEP;
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline registers.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, vo_r;
  item_t it1_r, it2_r, it3_r, it4_r, it5_r, it6_r, it7_r, it8_r;
  logic [VW-1:0] ep2_r, ev2_r, rp2_r, rv2_r;
  logic [VW-1:0] pa3_r, pb3_r, rp3_r, rv3_r;
  logic [VW-1:0] acc4_r, rp4_r, rv4_r;
  logic [VW-1:0] acc5_r, rp5_r, rv5_r;
  logic [VW-1:0] acc6_r, rp6_r, rv6_r;
  logic [VW-1:0] ta7_r, tb7_r, acc7_r, rp7_r, rv7_r;
  logic [VW-1:0] diff8_r, acc8_r, rp8_r, rv8_r;
  logic [jiftq_pkg::JOINT_W-1:0] jo_r;
  logic [VW-1:0] tq_r, rpo_r, rvo_r, acco_r;

  // Per-entry valid bits stand in for the reset value of the RAMs.
  logic [jiftq_pkg::JOINT_COUNT-1:0] ref_ok_r, goal_ok_r;

  // --------------------------------------------------------------------------
  // Stage load enables, from the output backward.
  // --------------------------------------------------------------------------
  logic ld_o, ld8, ld7, ld6, ld5, ld4, ld3, ld2, ld1;
  logic leave6;

  assign ld_o   = !vo_r || out_ch.ready;
  assign ld8    = !v8_r || ld_o;
  assign ld7    = !v7_r || ld8;
  assign leave6 = !is_step(it6_r.cmd) || ld7;
  assign ld6    = !v6_r || leave6;
  assign ld5    = !v5_r || ld6;
  assign ld4    = !v4_r || ld5;
  assign ld3    = !v3_r || ld4;
  assign ld2    = !v2_r || ld3;
  assign ld1    = !v1_r || ld2;

  // --------------------------------------------------------------------------
  // Input acceptance with an interlock on joints still in flight.
  // --------------------------------------------------------------------------
  logic    hazard;
  logic    in_keep;
  logic    take;
  item_t   in_item;
  logic [AW-1:0] rd_addr;

  always_comb begin
    hazard = (v1_r && it1_r.joint == in_ch.joint) ||
             (v2_r && it2_r.joint == in_ch.joint) ||
             (v3_r && it3_r.joint == in_ch.joint) ||
             (v4_r && it4_r.joint == in_ch.joint) ||
             (v5_r && it5_r.joint == in_ch.joint) ||
             (v6_r && it6_r.joint == in_ch.joint);
  end

  assign in_ch.ready = ld1 && !hazard;
  assign take        = in_ch.valid && in_ch.ready;
  assign in_keep     = (32'(in_ch.joint) < jiftq_pkg::JOINT_COUNT) &&
                       (in_ch.cmd == jiftq_pkg::CMD_STEP ||
                        in_ch.cmd == jiftq_pkg::CMD_TARGET ||
                        in_ch.cmd == jiftq_pkg::CMD_SYNC);
  assign rd_addr     = AW'(in_ch.joint);

  always_comb begin
    in_item.cmd   = in_ch.cmd;
    in_item.joint = in_ch.joint;
    in_item.q     = in_ch.measured_position;
    in_item.dq    = in_ch.measured_velocity;
    in_item.cor   = in_ch.coriolis_torque;
    in_item.prior = in_ch.prior_torque;
    in_item.tp    = in_ch.target_position;
    in_item.tv    = in_ch.target_velocity;
  end

  // --------------------------------------------------------------------------
  // State memories and write-back from stage six.
  // --------------------------------------------------------------------------
  logic [RW-1:0] ref_rdata, goal_rdata;
  logic [RW-1:0] ref_wdata, goal_wdata;
  logic          ref_we, goal_we;
  logic [AW-1:0] wr_addr;
  logic          wb;

  assign wb      = v6_r && leave6;
  assign wr_addr = AW'(it6_r.joint);
  assign ref_we  = wb && (is_step(it6_r.cmd) || it6_r.cmd == jiftq_pkg::CMD_SYNC);
  assign goal_we = wb && (it6_r.cmd == jiftq_pkg::CMD_TARGET ||
                          it6_r.cmd == jiftq_pkg::CMD_SYNC);

  always_comb begin
    if (is_step(it6_r.cmd)) begin
      ref_wdata = {rp6_r, rv6_r};
    end else begin
      ref_wdata = {it6_r.q, it6_r.dq};
    end
    if (it6_r.cmd == jiftq_pkg::CMD_TARGET) begin
      goal_wdata = {it6_r.tp, it6_r.tv};
    end else begin
      goal_wdata = {it6_r.q, {VW{1'b0}}};
    end
  end

  jiftq_ram #(.WIDTH(RW), .DEPTH(jiftq_pkg::JOINT_COUNT)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (wr_addr),
    .wdata (ref_wdata),
    .re    (take && in_keep),
    .raddr (rd_addr),
    .rdata (ref_rdata)
  );

  jiftq_ram #(.WIDTH(RW), .DEPTH(jiftq_pkg::JOINT_COUNT)) u_goal_ram (
    .clk   (clk),
    .we    (goal_we),
    .waddr (wr_addr),
    .wdata (goal_wdata),
    .re    (take && in_keep),
    .raddr (rd_addr),
    .rdata (goal_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage one: state read back, errors of the reference filter.
  // --------------------------------------------------------------------------
  logic [AW-1:0] addr1;
  logic [RW-1:0] ref1, goal1;
  logic [VW-1:0] rp1, rv1, ep1, ev1;

  assign addr1 = AW'(it1_r.joint);
  assign ref1  = ref_ok_r[addr1]  ? ref_rdata  : '0;
  assign goal1 = goal_ok_r[addr1] ? goal_rdata : '0;
  assign rp1   = ref1[RW-1:VW];
  assign rv1   = ref1[VW-1:0];
  assign ep1   = sub_s(goal1[RW-1:VW], rp1);
  assign ev1   = sub_s(goal1[VW-1:0], rv1);

  // --------------------------------------------------------------------------
  // Valid bits of stages and memory entries.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      v7_r      <= 1'b0;
      v8_r      <= 1'b0;
      vo_r      <= 1'b0;
      ref_ok_r  <= '0;
      goal_ok_r <= '0;
    end else begin
      if (ld1) v1_r <= take && in_keep;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
      if (ld6) v6_r <= v5_r;
      if (ld7) v7_r <= v6_r && is_step(it6_r.cmd);
      if (ld8) v8_r <= v7_r;
      if (ld_o) vo_r <= v8_r;
      if (ref_we) ref_ok_r[wr_addr] <= 1'b1;
      if (goal_we) goal_ok_r[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // Stage one: captured input transaction.
    if (ld1) begin
      it1_r <= in_item;
    end
    // Stage two: filter errors.
    if (ld2) begin
      it2_r <= it1_r;
      ep2_r <= ep1;
      ev2_r <= ev1;
      rp2_r <= rp1;
      rv2_r <= rv1;
    end
    // Stage three: filter gain products.
    if (ld3) begin
      it3_r <= it2_r;
      pa3_r <= mulq(ep2_r, {1'b0, cfg.filt_stiff}, 1'b0);
      pb3_r <= mulq(ev2_r, {1'b0, cfg.filt_damp}, 1'b0);
      rp3_r <= rp2_r;
      rv3_r <= rv2_r;
    end
    // Stage four: clamped filter acceleration.
    if (ld4) begin
      it4_r  <= it3_r;
      acc4_r <= clamp_s(add_s(pa3_r, pb3_r), cfg.accel_limit);
      rp4_r  <= rp3_r;
      rv4_r  <= rv3_r;
    end
    // Stage five: integrated, clamped velocity.
    if (ld5) begin
      it5_r  <= it4_r;
      acc5_r <= acc4_r;
      rv5_r  <= clamp_s(add_s(rv4_r, mulq(acc4_r, cfg.time_step, 1'b1)),
                        cfg.vel_limit);
      rp5_r  <= rp4_r;
    end
    // Stage six: integrated position; state is written back from here.
    if (ld6) begin
      it6_r  <= it5_r;
      acc6_r <= acc5_r;
      rv6_r  <= rv5_r;
      rp6_r  <= add_s(rp5_r, mulq(rv5_r, cfg.time_step, 1'b1));
    end
    // Stage seven: PD gain products.
    if (ld7) begin
      it7_r  <= it6_r;
      ta7_r  <= mulq(sub_s(rp6_r, it6_r.q), {1'b0, cfg.stiffness}, 1'b0);
      tb7_r  <= mulq(sub_s(rv6_r, it6_r.dq), {1'b0, cfg.damping}, 1'b0);
      acc7_r <= acc6_r;
      rp7_r  <= rp6_r;
      rv7_r  <= rv6_r;
    end
    // Stage eight: torque change against the prior command.
    if (ld8) begin
      it8_r   <= it7_r;
      diff8_r <= sub_s(add_s(add_s(ta7_r, tb7_r), it7_r.cor), it7_r.prior);
      acc8_r  <= acc7_r;
      rp8_r   <= rp7_r;
      rv8_r   <= rv7_r;
    end
    // Output register: rate-limited torque.
    if (ld_o) begin
      jo_r   <= it8_r.joint;
      tq_r   <= add_s(it8_r.prior, clamp_s(diff8_r, cfg.step_limit));
      rpo_r  <= rp8_r;
      rvo_r  <= rv8_r;
      acco_r <= acc8_r;
    end
  end

  assign out_ch.valid             = vo_r;
  assign out_ch.out_joint         = jo_r;
  assign out_ch.torque_command    = tq_r;
  assign out_ch.filtered_position = rpo_r;
  assign out_ch.filtered_velocity = rvo_r;
  assign out_ch.filtered_accel    = acco_r;

endmodule

[rtl/joint_impedance_filtered_torque.sv]
// Result path: a control step's input passes through the stage registers and the output
// register before its result is valid. Throughput: one transaction per cycle while joints
// differ and the output is not stalled; the state RAM write-back sits six stages deep, so
// a transaction on a joint still in those stages waits until that item is written back.
// Reset: synchronous, active low; configuration registers and stage valid bits take their
// defaults, and per-joint valid bits make all filter and goal state read as zero, with no clearing pass.
// ----------------------------------------------------------------------------
// Joint impedance filtered torque: top level
// Per-joint impedance controller with a second-order reference filter.
// ----------------------------------------------------------------------------
module joint_impedance_filtered_torque #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  jiftq_in_if.sink      in_ch,
  jiftq_out_if.source   out_ch,
  jiftq_cfg_if.sink     cfg_ch
);

  jiftq_pkg::cfg_t cfg;

  // Configuration registers.
  jiftq_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Filter and torque datapath around the joint state RAMs.
  jiftq_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
